@@ sv/brp_pkg.sv @@
// brp_pkg: shared types, constants and helpers of the bus read patch table
// used by brp_ctrl, brp_datapath and bus_read_patch_table_core
// no dependencies
`default_nettype none

package brp_pkg;

   // table geometry
   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // field widths
   localparam int ADDR_W  = 24;
   localparam int DATA_W  = 8;
   localparam int INDEX_W = 4;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 56;

   // work-ram mirror folding
   localparam logic [ADDR_W-1:0] MIRROR_SELECT = 24'h40e000;
   localparam logic [ADDR_W-1:0] MIRROR_BANK   = 24'h7e0000;
   localparam logic [ADDR_W-1:0] MIRROR_OFFSET = 24'h001fff;

   // operation codes
   typedef enum logic [2:0] {
      OP_LOOKUP  = 3'd0,
      OP_ADD     = 3'd1,
      OP_EDIT    = 3'd2,
      OP_REMOVE  = 3'd3,
      OP_ENABLE  = 3'd4,
      OP_DISABLE = 3'd5,
      OP_CLEAR   = 3'd6,
      OP_READ    = 3'd7
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FLAG_WR,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // request transaction, first field in the highest bits
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               enable_flag;
      logic [DATA_W-1:0]  data;
      logic [ADDR_W-1:0]  address;
      op_type             op;
   } item_type;

   // response transaction, first field in the highest bits
   typedef struct packed {
      logic [5:0]        pad;
      logic [DATA_W-1:0] entry_data;
      logic [ADDR_W-1:0] entry_address;
      logic              entry_enabled;
      logic [4:0]        entry_count;
      logic              any_enabled;
      status_type        status;
      logic [DATA_W-1:0] substitute_data;
      logic              hit;
   } result_type;

   // one table entry
   typedef struct packed {
      logic              enabled;
      logic [DATA_W-1:0] data;
      logic [ADDR_W-1:0] address;
   } entry_type;

   // controller to datapath commands
   typedef struct packed {
      logic       accept;      // capture request, clear accumulators
      logic       wr_add;      // write request entry at count, count up
      logic       wr_edit;     // write request entry at index
      logic       rd_index;    // read entry at index
      logic       wr_flag;     // write back read entry with new enable
      logic       ptr_zero;
      logic       ptr_index;
      logic       shift_rd;    // read entry at ptr + 1
      logic       shift_wr;    // write read entry at ptr, ptr up
      logic       count_dec;
      logic       count_clear;
      logic       scan_rd;     // read entry at ptr, ptr up
      logic       status_we;
      status_type status_code;
      logic       out_load;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      op_type op;
      logic   full;
      logic   idx_valid;
      logic   shift_more;
      logic   scan_more;
      logic   out_free;
   } ctl_status_type;

   // fold work-ram mirrors onto bank 7e
   function automatic logic [ADDR_W-1:0] fold_mirror(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] folded;
      if ((a & MIRROR_SELECT) != '0) begin
         folded = a;
      end else begin
         folded = MIRROR_BANK | (a & MIRROR_OFFSET);
      end
      return folded;
   endfunction

endpackage

`default_nettype wire

@@ sv/brp_ctrl.sv @@
// brp_ctrl: sequencing state machine of the patch table
// depends on brp_pkg; drives brp_datapath through ctl_cmd_type
`default_nettype none

module brp_ctrl import brp_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire ctl_status_type stat,
   output ctl_cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (stat.op)
               OP_REMOVE: begin
                  state_in = stat.idx_valid ? ST_SHIFT_RD : ST_SCAN;
               end
               OP_ENABLE, OP_DISABLE: begin
                  state_in = stat.idx_valid ? ST_FLAG_WR : ST_SCAN;
               end
               default: state_in = ST_SCAN;
            endcase
         end
         ST_FLAG_WR: state_in = ST_SCAN;
         ST_SHIFT_RD: begin
            state_in = stat.shift_more ? ST_SHIFT_WR : ST_SCAN;
         end
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_SCAN: begin
            if (!stat.scan_more) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd             = '0;
      cmd.status_code = STATUS_OK;
      req_tready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_EXEC: begin
            cmd.ptr_zero = 1'b1;
            case (stat.op)
               OP_LOOKUP: begin
               end
               OP_ADD: begin
                  if (stat.full) begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = STATUS_FULL;
                  end else begin
                     cmd.wr_add = 1'b1;
                  end
               end
               OP_EDIT: begin
                  if (stat.idx_valid) begin
                     cmd.wr_edit = 1'b1;
                  end else begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = STATUS_BAD_INDEX;
                  end
               end
               OP_REMOVE: begin
                  if (stat.idx_valid) begin
                     cmd.ptr_zero  = 1'b0;
                     cmd.ptr_index = 1'b1;
                  end else begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = STATUS_BAD_INDEX;
                  end
               end
               OP_ENABLE, OP_DISABLE: begin
                  if (stat.idx_valid) begin
                     cmd.rd_index = 1'b1;
                  end else begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = STATUS_BAD_INDEX;
                  end
               end
               OP_CLEAR: begin
                  cmd.count_clear = 1'b1;
               end
               OP_READ: begin
                  if (!stat.idx_valid) begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = STATUS_BAD_INDEX;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_FLAG_WR: begin
            cmd.wr_flag  = 1'b1;
            cmd.ptr_zero = 1'b1;
         end
         ST_SHIFT_RD: begin
            if (stat.shift_more) begin
               cmd.shift_rd = 1'b1;
            end else begin
               cmd.count_dec = 1'b1;
               cmd.ptr_zero  = 1'b1;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_rd = stat.scan_more;
         end
         ST_FINISH: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/brp_datapath.sv @@
// brp_datapath: entry memory, count, scan pointer, lookup compare and response register
// depends on brp_pkg; commanded by brp_ctrl
`default_nettype none

module brp_datapath import brp_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic             rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_W-1:0]      rsp_tdata,
   input  wire ctl_cmd_type      cmd,
   output ctl_status_type        stat
);

   // entry memory, no reset
   entry_type slot_mem [MAX_ENTRIES];

   item_type               item_ff, item_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       ptr_ff, ptr_in;
   logic                   scan_valid_ff, scan_valid_in;
   logic [IDX_W-1:0]       scan_addr_ff, scan_addr_in;
   entry_type              rdata_ff;
   status_type             status_ff, status_in;
   logic                   hit_ff, hit_in;
   logic [DATA_W-1:0]      sub_ff, sub_in;
   logic                   any_ff, any_in;
   entry_type              read_entry_ff, read_entry_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]  ptr_plus1;
   logic [IDX_W-1:0]  idx_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              key_match;

   assign ptr_plus1 = CNT_W'(ptr_ff + 1'b1);
   assign idx_addr  = IDX_W'(item_ff.index);

   // status toward the controller
   assign stat.op         = item_ff.op;
   assign stat.full       = (count_ff >= CNT_W'(MAX_ENTRIES));
   assign stat.idx_valid  = (32'(item_ff.index) < 32'(count_ff));
   assign stat.shift_more = (ptr_plus1 < count_ff);
   assign stat.scan_more  = (ptr_ff < count_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   // memory write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_addr;
      wr_data = '{enabled: item_ff.enable_flag, data: item_ff.data,
                  address: item_ff.address};
      if (cmd.wr_add) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
      end else if (cmd.wr_edit) begin
         wr_en = 1'b1;
      end else if (cmd.wr_flag) begin
         wr_en           = 1'b1;
         wr_data         = rdata_ff;
         wr_data.enabled = (item_ff.op == OP_ENABLE);
      end else if (cmd.shift_wr) begin
         wr_en   = 1'b1;
         wr_addr = ptr_ff[IDX_W-1:0];
         wr_data = rdata_ff;
      end
   end

   // memory read port select
   always_comb begin
      rd_en   = cmd.rd_index || cmd.shift_rd || cmd.scan_rd;
      rd_addr = idx_addr;
      if (cmd.shift_rd) begin
         rd_addr = ptr_plus1[IDX_W-1:0];
      end else if (cmd.scan_rd) begin
         rd_addr = ptr_ff[IDX_W-1:0];
      end
   end

   // entry memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= slot_mem[rd_addr];
      end
   end

   // folded address compare of the scanned entry
   assign key_match = (fold_mirror(rdata_ff.address) == fold_mirror(item_ff.address));

   // next values of count, pointer and accumulators
   always_comb begin
      item_in       = item_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      scan_valid_in = cmd.scan_rd;
      scan_addr_in  = ptr_ff[IDX_W-1:0];
      status_in     = status_ff;
      hit_in        = hit_ff;
      sub_in        = sub_ff;
      any_in        = any_ff;
      read_entry_in = read_entry_ff;

      if (cmd.accept) begin
         item_in       = item_type'(req_tdata);
         status_in     = STATUS_OK;
         hit_in        = 1'b0;
         sub_in        = '0;
         any_in        = 1'b0;
         read_entry_in = '0;
      end
      if (cmd.status_we) begin
         status_in = cmd.status_code;
      end

      // entry count
      if (cmd.wr_add) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (cmd.count_dec) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end else if (cmd.count_clear) begin
         count_in = '0;
      end

      // walk pointer
      if (cmd.ptr_zero) begin
         ptr_in = '0;
      end else if (cmd.ptr_index) begin
         ptr_in = CNT_W'(item_ff.index);
      end else if (cmd.shift_wr || cmd.scan_rd) begin
         ptr_in = ptr_plus1;
      end

      // scan evaluation, first enabled match wins
      if (scan_valid_ff) begin
         if (rdata_ff.enabled) begin
            any_in = 1'b1;
         end
         if (item_ff.op == OP_LOOKUP && !hit_ff && rdata_ff.enabled && key_match) begin
            hit_in = 1'b1;
            sub_in = rdata_ff.data;
         end
         if (item_ff.op == OP_READ && status_ff == STATUS_OK
             && scan_addr_ff == idx_addr) begin
            read_entry_in = rdata_ff;
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.pad             = '0;
         rsp_data_in.hit             = hit_ff;
         rsp_data_in.substitute_data = sub_ff;
         rsp_data_in.status          = status_ff;
         rsp_data_in.any_enabled     = any_ff;
         rsp_data_in.entry_count     = 5'(count_ff);
         rsp_data_in.entry_enabled   = read_entry_ff.enabled;
         rsp_data_in.entry_address   = read_entry_ff.address;
         rsp_data_in.entry_data      = read_entry_ff.data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ptr_ff        <= '0;
         scan_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         scan_valid_ff <= scan_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      scan_addr_ff  <= scan_addr_in;
      status_ff     <= status_in;
      hit_ff        <= hit_in;
      sub_ff        <= sub_in;
      any_ff        <= any_in;
      read_entry_ff <= read_entry_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ sv/bus_read_patch_table_core.sv @@
// Sequence: a transaction is taken in idle; the state machine then scans every stored entry
// (enable/disable first write the flag back, a valid remove first shifts the entries above
// the index down) and loads the response once the response register is free.
// Throughput: one transaction at a time, set by the one-entry-per-cycle scan through the
// entry memory and its single read port (remove adds the shift).
// Reset: synchronous; clears the entry count, state machine and response valid;
// entry contents stay undefined, no clearing pass.
`default_nettype none

module bus_read_patch_table_core import brp_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // op, address, data, enable_flag, index
   // response channel
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata    // hit, substitute_data, status, any_enabled,
                                              // entry_count, entry_enabled, entry_address,
                                              // entry_data, zero fill
);

   ctl_cmd_type    cmd;
   ctl_status_type stat;
   result_type     rsp_view;

   // sequencer
   brp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // table storage and compare
   brp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   assign rsp_view = result_type'(rsp_tdata);

`ifndef SYNTHESIS
   // one transaction in flight: no new request right after one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   // a hit needs an enabled entry
   a_hit_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.hit |-> rsp_view.any_enabled)
      else $error("hit reported with no enabled entry");

   // table full only at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.status == STATUS_FULL
      |-> 32'(rsp_view.entry_count) == MAX_ENTRIES)
      else $error("table full reported below capacity");

   // count never beyond capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_view.entry_count) <= MAX_ENTRIES)
      else $error("entry count beyond capacity");
`endif

endmodule

`default_nettype wire
